// File: rtl/pse_pkg.sv
// shared types, constants and checksum helpers for the png stored-deflate encoder
package pse_pkg;

    localparam int DIM_W   = 13;
    localparam int RAW_W   = 28;
    localparam int STEP_W  = 6;
    localparam int CIDX_W  = 2;

    localparam logic [CIDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CIDX_W-1:0] REG_HEIGHT = 2'd1;

    localparam logic CMD_BEGIN = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;
    localparam logic [31:0] IEND_CRC  = 32'hAE426082;
    localparam logic [16:0] ADLER_MOD = 17'd65521;
    localparam logic [15:0] BLOCK_MAX = 16'hFFFF;

    localparam logic [STEP_W-1:0] PRO_LAST = 6'd42;
    localparam logic [STEP_W-1:0] TRL_LAST = 6'd19;

    typedef struct packed {
        logic        command;
        logic [31:0] pixel_rgba;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       stream_last;
    } t_out_item;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [RAW_W-1:0] raw_len;
        logic [31:0]      idat_len;
    } t_frame_info;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRO,
        ST_PIX,
        ST_TRL
    } t_state;

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

    // big-endian byte pick, idx 0 is the top byte
    function automatic logic [7:0] be_byte(input logic [31:0] v, input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = v[31:24];
            2'd1:    b = v[23:16];
            2'd2:    b = v[15:8];
            default: b = v[7:0];
        endcase
        return b;
    endfunction

endpackage

// File: rtl/pse_frame_calc.sv
// clamps the image size and derives the raw length and idat chunk length
module pse_frame_calc
    import pse_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic             i_clk,
    input  logic [DIM_W-1:0] i_width,
    input  logic [DIM_W-1:0] i_height,
    output t_frame_info      o_info
);

    localparam int DIM_TOP = (1 << DIM_W) - 1;
    localparam logic [DIM_W-1:0] W_MAX = DIM_W'((MAX_WIDTH  > DIM_TOP) ? DIM_TOP : MAX_WIDTH);
    localparam logic [DIM_W-1:0] H_MAX = DIM_W'((MAX_HEIGHT > DIM_TOP) ? DIM_TOP : MAX_HEIGHT);
    localparam int Q_W = RAW_W - 16;

    logic [DIM_W-1:0] r_w, r_h;
    logic [RAW_W-1:0] r_raw, r_raw2;
    logic [Q_W:0]     r_nb;
    logic [31:0]      r_idat;

    logic [DIM_W+1:0] row_bytes;
    logic [Q_W-1:0]   q0;
    logic [16:0]      rem0;
    logic [Q_W:0]     q1;
    logic [16:0]      rem1;

    always_comb begin
        row_bytes = {1'b0, r_w, 1'b0} + {2'b0, r_w} + (DIM_W+2)'(1);
        // raw / 65535: 2^16 = 65535 + 1, so remainder is low half plus quotient
        q0   = r_raw[RAW_W-1:16];
        rem0 = {1'b0, r_raw[15:0]} + 17'(q0);
        if (rem0 >= 17'(BLOCK_MAX)) begin
            q1   = {1'b0, q0} + (Q_W+1)'(1);
            rem1 = rem0 - 17'(BLOCK_MAX);
        end else begin
            q1   = {1'b0, q0};
            rem1 = rem0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w    <= (i_width == '0) ? DIM_W'(1) : ((i_width > W_MAX) ? W_MAX : i_width);
        r_h    <= (i_height == '0) ? DIM_W'(1) : ((i_height > H_MAX) ? H_MAX : i_height);
        r_raw  <= RAW_W'(r_h) * RAW_W'(row_bytes);
        r_raw2 <= r_raw;
        r_nb   <= q1 + (Q_W+1)'(rem1 != '0);
        r_idat <= 32'd6 + 32'(r_raw2) + 32'({r_nb, 2'b00}) + 32'(r_nb);
    end

    assign o_info = '{width: r_w, height: r_h, raw_len: r_raw2, idat_len: r_idat};

endmodule

// File: rtl/pse_emitter.sv
// byte sequencer: prologue, pixel bytes with block headers, trailer, running checksums
module pse_emitter
    import pse_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_in_item    i_item,
    input  t_frame_info i_info,
    input  logic        i_adv,
    output logic        o_active,
    output logic        o_emit,
    output t_out_item   o_byte
);

    t_state             r_state, n_state;
    logic [STEP_W-1:0]  r_step, n_step;
    logic [1:0]         r_k, n_k;
    logic [2:0]         r_hs, n_hs;
    logic [23:0]        r_px, n_px;
    logic [31:0]        r_hcrc, n_hcrc;
    logic [31:0]        r_crc, n_crc;
    logic [15:0]        r_alo, n_alo;
    logic [15:0]        r_ahi, n_ahi;
    logic [15:0]        r_fill, n_fill;
    logic [RAW_W-1:0]   r_left, n_left;
    logic               r_open, n_open;
    logic [DIM_W-1:0]   r_col, n_col;

    logic [7:0]  b;
    logic        b_last, b_end, b_idat;
    logic [15:0] blk_n;
    logic [16:0] s_lo, s_hi, m_lo, m_hi;
    logic [DIM_W:0] col_inc;

    always_comb begin
        blk_n   = (r_left > RAW_W'(BLOCK_MAX)) ? BLOCK_MAX : r_left[15:0];
        col_inc = {1'b0, r_col} + (DIM_W+1)'(1);
        b       = 8'd0;
        b_last  = 1'b0;
        b_end   = 1'b0;
        b_idat  = 1'b0;
        case (r_state)
            ST_PRO: begin
                case (r_step)
                    6'd0:  b = 8'd137;
                    6'd1:  b = 8'd80;
                    6'd2:  b = 8'd78;
                    6'd3:  b = 8'd71;
                    6'd4:  b = 8'd13;
                    6'd5:  b = 8'd10;
                    6'd6:  b = 8'd26;
                    6'd7:  b = 8'd10;
                    6'd11: b = 8'd13;
                    6'd12: b = 8'd73;
                    6'd13: b = 8'd72;
                    6'd14: b = 8'd68;
                    6'd15: b = 8'd82;
                    6'd18: b = 8'(i_info.width >> 8);
                    6'd19: b = i_info.width[7:0];
                    6'd22: b = 8'(i_info.height >> 8);
                    6'd23: b = i_info.height[7:0];
                    6'd24: b = 8'd8;
                    6'd25: b = 8'd2;
                    6'd29, 6'd30, 6'd31, 6'd32: b = be_byte(~r_hcrc, 2'(r_step - 6'd29));
                    6'd33, 6'd34, 6'd35, 6'd36: b = be_byte(i_info.idat_len, 2'(r_step - 6'd33));
                    6'd37: b = 8'd73;
                    6'd38: b = 8'd68;
                    6'd39: b = 8'd65;
                    6'd40: b = 8'd84;
                    6'd41: b = 8'h78;
                    6'd42: b = 8'h01;
                    default: b = 8'd0;
                endcase
                b_idat = (r_step >= 6'd37);
                b_last = (r_step == PRO_LAST);
            end
            ST_PIX: begin
                b_idat = 1'b1;
                if (r_fill == '0) begin
                    case (r_hs)
                        3'd0:    b = {7'd0, r_left <= RAW_W'(BLOCK_MAX)};
                        3'd1:    b = blk_n[7:0];
                        3'd2:    b = blk_n[15:8];
                        3'd3:    b = ~blk_n[7:0];
                        default: b = ~blk_n[15:8];
                    endcase
                end else begin
                    case (r_k)
                        2'd0:    b = 8'd0;
                        2'd1:    b = r_px[23:16];
                        2'd2:    b = r_px[15:8];
                        default: b = r_px[7:0];
                    endcase
                    b_last = (r_k == 2'd3) && (r_left != RAW_W'(1));
                end
            end
            ST_TRL: begin
                case (r_step)
                    6'd0, 6'd1, 6'd2, 6'd3: b = be_byte({r_ahi, r_alo}, r_step[1:0]);
                    6'd4, 6'd5, 6'd6, 6'd7: b = be_byte(~r_crc, r_step[1:0]);
                    6'd12: b = 8'd73;
                    6'd13: b = 8'd69;
                    6'd14: b = 8'd78;
                    6'd15: b = 8'd68;
                    6'd16, 6'd17, 6'd18, 6'd19: b = be_byte(IEND_CRC, r_step[1:0]);
                    default: b = 8'd0;
                endcase
                b_idat = (r_step <= 6'd3);
                b_last = (r_step == TRL_LAST);
                b_end  = b_last;
            end
            default: ;
        endcase
    end

    assign o_active = (r_state != ST_IDLE);
    assign o_emit   = o_active && i_adv;
    assign o_byte   = '{out_byte: b, run_last: b_last, stream_last: b_end};

    always_comb begin
        s_lo = {1'b0, r_alo} + 17'(b);
        m_lo = (s_lo >= ADLER_MOD) ? s_lo - ADLER_MOD : s_lo;
        s_hi = {1'b0, r_ahi} + m_lo;
        m_hi = (s_hi >= ADLER_MOD) ? s_hi - ADLER_MOD : s_hi;

        n_state = r_state;
        n_step  = r_step;
        n_k     = r_k;
        n_hs    = r_hs;
        n_px    = r_px;
        n_hcrc  = r_hcrc;
        n_crc   = r_crc;
        n_alo   = r_alo;
        n_ahi   = r_ahi;
        n_fill  = r_fill;
        n_left  = r_left;
        n_open  = r_open;
        n_col   = r_col;

        if (o_emit) begin
            if (b_idat) begin
                n_crc = crc_byte(r_crc, b);
            end
            case (r_state)
                ST_PRO: begin
                    if (r_step >= 6'd12 && r_step <= 6'd28) begin
                        n_hcrc = crc_byte(r_hcrc, b);
                    end
                    if (r_step == 6'd33) begin
                        n_left = i_info.raw_len;
                    end
                    n_step = r_step + 6'd1;
                    if (b_last) begin
                        n_state = ST_IDLE;
                    end
                end
                ST_PIX: begin
                    if (r_fill == '0) begin
                        if (r_hs == 3'd4) begin
                            n_hs   = 3'd0;
                            n_fill = blk_n;
                        end else begin
                            n_hs = r_hs + 3'd1;
                        end
                    end else begin
                        n_alo  = m_lo[15:0];
                        n_ahi  = m_hi[15:0];
                        n_fill = r_fill - 16'd1;
                        n_left = r_left - RAW_W'(1);
                        n_k    = r_k + 2'd1;
                        if (r_left == RAW_W'(1)) begin
                            // frame length used up, trailer follows
                            n_open  = 1'b0;
                            n_state = ST_TRL;
                            n_step  = '0;
                        end else if (r_k == 2'd3) begin
                            n_state = ST_IDLE;
                        end
                    end
                end
                ST_TRL: begin
                    n_step = r_step + 6'd1;
                    if (b_last) begin
                        n_state = ST_IDLE;
                    end
                end
                default: ;
            endcase
        end

        if (i_load) begin
            if (i_item.command == CMD_BEGIN) begin
                n_state = ST_PRO;
                n_step  = '0;
                n_open  = 1'b1;
                n_col   = '0;
                n_hcrc  = CRC_INIT;
                n_crc   = CRC_INIT;
                n_alo   = 16'd1;
                n_ahi   = 16'd0;
                n_fill  = '0;
            end else if (n_open) begin
                n_state = ST_PIX;
                n_k     = (r_col == '0) ? 2'd0 : 2'd1;
                n_hs    = 3'd0;
                n_px    = i_item.pixel_rgba[31:8];
                n_col   = (col_inc >= {1'b0, i_info.width}) ? '0 : col_inc[DIM_W-1:0];
            end else begin
                n_state = ST_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_open  <= 1'b0;
            r_col   <= '0;
            r_crc   <= CRC_INIT;
            r_alo   <= 16'd1;
            r_ahi   <= 16'd0;
            r_fill  <= '0;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_open  <= n_open;
            r_col   <= n_col;
            r_crc   <= n_crc;
            r_alo   <= n_alo;
            r_ahi   <= n_ahi;
            r_fill  <= n_fill;
            r_left  <= n_left;
        end
        r_step <= n_step;
        r_k    <= n_k;
        r_hs   <= n_hs;
        r_px   <= n_px;
        r_hcrc <= n_hcrc;
    end

endmodule

// File: rtl/png_stored_deflate_encoder_top.sv
// channel     | signals                             | payload
// input item  | i_in_valid / o_in_ready             | i_in_item (command, pixel_rgba)
// result item | o_out_valid / i_out_ready           | o_out_item (out_byte, run_last, stream_last)
// config      | i_cfg_valid / o_cfg_ready           | i_cfg_index, i_cfg_data
//
// one byte per unstalled cycle: a pixel is 3 bytes, 4 at a row start, 5 more at a block start
// a begin item gives 43 bytes, the pixel that ends the frame 20 more for the trailer
// the byte sequencer sets the pace; the next item is taken on the cycle of the previous last byte
// reset is synchronous, active low; no clearing pass
// a stalled output holds the sequencer, the input buffer still takes one item
module png_stored_deflate_encoder_top
    import pse_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_item,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]  i_cfg_data
);

    logic [DIM_W-1:0] r_width, r_height;
    logic             r_in_valid;
    t_in_item         r_in_item;
    logic             r_out_valid;
    t_out_item        r_out_item;

    t_frame_info info;
    logic        adv, active, emit, take;
    t_out_item   byte_item;

    assign o_cfg_ready = 1'b1;
    assign adv         = !r_out_valid || i_out_ready;
    assign take        = r_in_valid && (!active || (emit && byte_item.run_last));
    assign o_in_ready  = !r_in_valid || take;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    pse_frame_calc #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_calc (
        .i_clk    (i_clk),
        .i_width  (r_width),
        .i_height (r_height),
        .o_info   (info)
    );

    pse_emitter u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (take),
        .i_item   (r_in_item),
        .i_info   (info),
        .i_adv    (adv),
        .o_active (active),
        .o_emit   (emit),
        .o_byte   (byte_item)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= DIM_W'(1);
            r_height    <= DIM_W'(1);
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_WIDTH:  r_width  <= i_cfg_data;
                    REG_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (adv) begin
                r_out_valid <= emit;
            end
        end
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
        if (emit) begin
            r_out_item <= byte_item;
        end
    end

`ifndef SYNTH
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.stream_last |-> o_out_item.run_last)
        else $error("stream end without item end");
    a_no_take_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> r_in_valid)
        else $error("sequencer took an empty buffer");
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !r_in_valid)
        else $error("valid after reset");
`endif

endmodule

// File: tb/testbench.sv
// testbench for the png stored-deflate encoder: byte-exact stream prediction and checking
`timescale 1ns / 1ps

module testbench
    import pse_pkg::*;
;

    localparam int MAXW = 4096;
    localparam int MAXH = 4096;
    localparam int WATCHDOG_LIMIT = 20000;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    t_in_item          in_item;
    logic              out_valid;
    logic              out_ready;
    t_out_item         out_item;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CIDX_W-1:0] cfg_index;
    logic [DIM_W-1:0]  cfg_data;
    logic              in_ready_q;
    logic              out_valid_q;

    png_stored_deflate_encoder_top DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // predictor state
    logic [12:0] enc_width;
    logic [12:0] enc_height;
    logic        enc_open;
    int unsigned enc_col;
    logic [31:0] enc_crc;
    logic [31:0] enc_adl_lo;
    logic [31:0] enc_adl_hi;
    int unsigned enc_blk_fill;
    int unsigned enc_raw_left;

    t_in_item  pending_items[$];
    t_out_item expected_bytes[$];
    logic [7:0] step_bytes[$];
    logic       step_stream_last;

    int unsigned mismatches;
    int unsigned bytes_checked;
    int unsigned items_sent;
    int unsigned frames_done;
    int unsigned idle_cycles;
    logic        stim_done;
    int unsigned drv_wait;
    int unsigned rcv_wait;

    function automatic logic [31:0] crc_step(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
        return c;
    endfunction

    function automatic int unsigned clamp_dim(input logic [12:0] v, input int unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    task automatic put_be32(input logic [31:0] v);
        step_bytes.push_back(v[31:24]);
        step_bytes.push_back(v[23:16]);
        step_bytes.push_back(v[15:8]);
        step_bytes.push_back(v[7:0]);
    endtask

    task automatic put_idat(input logic [7:0] b);
        enc_crc = crc_step(enc_crc, b);
        step_bytes.push_back(b);
    endtask

    task automatic put_raw(input logic [7:0] b);
        int unsigned n;
        logic [15:0] nn;
        if (enc_raw_left == 0) return;
        if (enc_blk_fill == 0) begin
            n = (enc_raw_left > 65535) ? 65535 : enc_raw_left;
            nn = ~n[15:0];
            put_idat((enc_raw_left <= 65535) ? 8'd1 : 8'd0);
            put_idat(n[7:0]);
            put_idat(n[15:8]);
            put_idat(nn[7:0]);
            put_idat(nn[15:8]);
            enc_blk_fill = n;
        end
        put_idat(b);
        enc_adl_lo = (enc_adl_lo + b) % 65521;
        enc_adl_hi = (enc_adl_hi + enc_adl_lo) % 65521;
        enc_blk_fill--;
        enc_raw_left--;
    endtask

    task automatic emit_header;
        logic [7:0] sig[8];
        logic [7:0] hdr[17];
        logic [31:0] c;
        int unsigned w, h, rawlen, nblk;
        sig = '{8'd137, 8'd80, 8'd78, 8'd71, 8'd13, 8'd10, 8'd26, 8'd10};
        w = clamp_dim(enc_width, MAXW);
        h = clamp_dim(enc_height, MAXH);
        hdr = '{"I", "H", "D", "R", w[31:24], w[23:16], w[15:8], w[7:0],
                h[31:24], h[23:16], h[15:8], h[7:0], 8'd8, 8'd2, 8'd0, 8'd0, 8'd0};
        c = 32'hFFFFFFFF;
        foreach (sig[i]) step_bytes.push_back(sig[i]);
        put_be32(32'd13);
        foreach (hdr[i]) begin
            step_bytes.push_back(hdr[i]);
            c = crc_step(c, hdr[i]);
        end
        put_be32(~c);
        rawlen = h * (1 + 3 * w);
        nblk = (rawlen + 65534) / 65535;
        put_be32(2 + rawlen + 5 * nblk + 4);
        enc_open = 1'b1;
        enc_col = 0;
        enc_crc = 32'hFFFFFFFF;
        enc_adl_lo = 1;
        enc_adl_hi = 0;
        enc_blk_fill = 0;
        enc_raw_left = rawlen;
        put_idat("I"); put_idat("D"); put_idat("A"); put_idat("T");
        put_idat(8'h78);
        put_idat(8'h01);
    endtask

    task automatic emit_trailer;
        logic [31:0] ad;
        logic [31:0] c;
        logic [7:0] tag[4];
        tag = '{"I", "E", "N", "D"};
        ad = {enc_adl_hi[15:0], enc_adl_lo[15:0]};
        put_idat(ad[31:24]); put_idat(ad[23:16]); put_idat(ad[15:8]); put_idat(ad[7:0]);
        put_be32(~enc_crc);
        put_be32(32'd0);
        c = 32'hFFFFFFFF;
        foreach (tag[i]) begin
            step_bytes.push_back(tag[i]);
            c = crc_step(c, tag[i]);
        end
        put_be32(~c);
        step_stream_last = 1'b1;
        enc_open = 1'b0;
        frames_done++;
    endtask

    // works out the bytes one accepted item causes
    task automatic encode_item(input t_in_item it);
        t_out_item r;
        int unsigned w;
        step_bytes.delete();
        step_stream_last = 1'b0;
        if (it.command == CMD_BEGIN) begin
            emit_header();
        end else if (enc_open) begin
            w = clamp_dim(enc_width, MAXW);
            if (enc_col == 0) put_raw(8'd0);
            put_raw(it.pixel_rgba[31:24]);
            put_raw(it.pixel_rgba[23:16]);
            put_raw(it.pixel_rgba[15:8]);
            enc_col++;
            if (enc_col >= w) enc_col = 0;
            if (enc_raw_left == 0) emit_trailer();
        end
        foreach (step_bytes[i]) begin
            r.out_byte = step_bytes[i];
            r.run_last = (i == step_bytes.size() - 1);
            r.stream_last = step_stream_last && r.run_last;
            expected_bytes.push_back(r);
        end
    endtask

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk) in_ready_q <= in_ready;
    always @(posedge clk) out_valid_q <= out_valid;

    // driver: a new item may follow an accepted one with no gap
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_ready_q) begin
            if (drv_wait > 0) begin
                in_valid <= 1'b0;
                drv_wait <= drv_wait - 1;
            end else if (pending_items.size() > 0) begin
                in_item <= pending_items.pop_front();
                in_valid <= 1'b1;
                drv_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver stall
    always @(negedge clk) begin
        int unsigned w;
        if (!rst_n) begin
            out_ready <= 1'b0;
            rcv_wait <= 0;
        end else if (out_ready && out_valid_q) begin
            w = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
            rcv_wait <= w;
            out_ready <= (w == 0);
        end else if (rcv_wait > 0) begin
            rcv_wait <= rcv_wait - 1;
            out_ready <= (rcv_wait == 1);
        end else begin
            out_ready <= 1'b1;
        end
    end

    // monitor: prediction on input accept, compare on output accept
    always @(posedge clk) begin
        t_out_item e;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                encode_item(in_item);
                items_sent++;
            end
            if (out_valid && out_ready) begin
                bytes_checked++;
                if (expected_bytes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected byte %02h run_last %0b stream_last %0b",
                                 out_item.out_byte, out_item.run_last, out_item.stream_last);
                end else begin
                    e = expected_bytes.pop_front();
                    if (e !== out_item) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("byte %0d: exp %02h/%0b/%0b got %02h/%0b/%0b",
                                     bytes_checked, e.out_byte, e.run_last, e.stream_last,
                                     out_item.out_byte, out_item.run_last,
                                     out_item.stream_last);
                    end
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic wait_drained;
        while (pending_items.size() > 0 || in_valid || expected_bytes.size() > 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_WIDTH) enc_width = val;
        else enc_height = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_pixel(input logic [31:0] px);
        t_in_item it;
        it.command = CMD_PIXEL;
        it.pixel_rgba = px;
        pending_items.push_back(it);
    endtask

    task automatic queue_begin;
        t_in_item it;
        it.command = CMD_BEGIN;
        it.pixel_rgba = $urandom;
        pending_items.push_back(it);
    endtask

    // one frame, optionally cut short, with random pixels
    task automatic run_frame(input logic [12:0] w, input logic [12:0] h, input int unsigned n);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        queue_begin();
        for (int i = 0; i < n; i++) queue_pixel($urandom);
        wait_drained();
    endtask

    initial begin
        int unsigned w, h;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_WIDTH;
        cfg_data = '0;
        drv_wait = 0;
        rcv_wait = 0;
        mismatches = 0;
        bytes_checked = 0;
        items_sent = 0;
        frames_done = 0;
        idle_cycles = 0;
        stim_done = 1'b0;
        enc_width = 1;
        enc_height = 1;
        enc_open = 1'b0;
        enc_col = 0;
        enc_crc = 32'hFFFFFFFF;
        enc_adl_lo = 1;
        enc_adl_hi = 0;
        enc_blk_fill = 0;
        enc_raw_left = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: pixel with no frame open, 1x1 frames with extreme pixels
        queue_pixel(32'hFFFFFFFF);
        queue_begin();
        queue_pixel(32'h00000000);
        queue_begin();
        queue_pixel(32'hFFFFFFFF);
        wait_drained();
        // zero dims clamp to one, oversize dims clamp to max
        run_frame(13'd0, 13'd0, 1);
        write_reg(REG_WIDTH, 13'h1FFF);
        write_reg(REG_HEIGHT, 13'h1FFF);
        queue_begin();
        queue_pixel(32'hA5A5A5A5);
        queue_pixel(32'h5A5A5A5A);
        wait_drained();
        // begin during a frame abandons it
        write_reg(REG_WIDTH, 13'd2);
        write_reg(REG_HEIGHT, 13'd2);
        queue_begin();
        queue_pixel(32'h12345678);
        wait_drained();
        // width change mid-frame: only the row wrap follows it
        write_reg(REG_WIDTH, 13'd1);
        queue_pixel(32'h87654321);
        queue_pixel(32'hDEADBEEF);
        queue_pixel(32'hCAFEF00D);
        wait_drained();
        // 3x3, every row wraps, frame finishes
        run_frame(13'd3, 13'd3, 9);
        // a single 4096-wide row stays within one block; multi-block frames need many rows,
        // so check a block header with a big (but short-run) frame
        run_frame(13'd4096, 13'd4096, 4);

        // random frames, mostly small and completed
        while (items_sent < 380) begin
            w = $urandom_range(1, 6);
            h = $urandom_range(1, 5);
            if ($urandom_range(0, 5) == 0)
                run_frame(13'(w), 13'(h), $urandom_range(0, w * h - 1));
            else
                run_frame(13'(w), 13'(h), w * h + $urandom_range(0, 1));
        end
        stim_done = 1'b1;
    end

    // end of run
    initial begin
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired, %0d bytes still expected", expected_bytes.size());
                $display("CHECK FAILED");
                $finish;
            end
            if (stim_done) begin
                $display("sent %0d items, checked %0d bytes, %0d frames finished",
                         items_sent, bytes_checked, frames_done);
                if (mismatches == 0 && expected_bytes.size() == 0)
                    $display("CHECK OK");
                else
                    $display("CHECK FAILED");
                $finish;
            end
        end
    end

endmodule

// File: files.f
rtl/pse_pkg.sv
rtl/pse_frame_calc.sv
rtl/pse_emitter.sv
rtl/png_stored_deflate_encoder_top.sv
tb/testbench.sv
